/* hdl/angle_frame_command_decoder_core_assert.svh */
// Assertion macros shared by the decoder modules.
// Both expect clk and rst_n in the enclosing scope.
`ifndef ANGLE_FRAME_COMMAND_DECODER_CORE_ASSERT_SVH
`define ANGLE_FRAME_COMMAND_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define AFCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afcd assertion failed");

// Next-cycle implication.
`define AFCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afcd assertion failed");

`endif

/* hdl/afcd_pkg.sv */
`timescale 1ns / 1ps

package afcd_pkg;

  localparam int unsigned WIN_LEN = 10;

  localparam logic [7:0] CH_OPEN    = 8'h3C;
  localparam logic [7:0] CH_CLOSE   = 8'h3E;
  localparam logic [7:0] CH_BIG_P   = 8'h50;
  localparam logic [7:0] CH_SMALL_P = 8'h70;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_Q       = 8'h51;
  localparam logic [7:0] CH_S       = 8'h53;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_ONE      = 3'd1,
    CMD_TWO      = 3'd2,
    CMD_Q        = 3'd3,
    CMD_S        = 3'd4,
    CMD_SETTINGS = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [15:0] setting_third;
    logic [15:0] setting_second;
    logic [15:0] setting_first;
    cmd_t        command;
  } result_t;

endpackage

/* hdl/afcd_frame.sv */
`timescale 1ns / 1ps

module afcd_frame import afcd_pkg::*; #(
  parameter int unsigned BUFFER_LENGTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       req_clear,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  localparam int unsigned FW = $clog2(BUFFER_LENGTH + 1);

  // A '<' always restarts at position 0 (as does a full buffer), so a '<' never sits above position 0
  // and decode only ever matches a frame starting there. Bytes past the
  // decode window are never read and are not stored.
  logic [7:0]    win_r   [WIN_LEN];
  logic [7:0]    win_nxt [WIN_LEN];
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] pos;
  cmd_t          cmd_r, cmd_nxt;
  logic [15:0]   words_r   [3];
  logic [15:0]   words_nxt [3];

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    cmd_nxt   = cmd_r;
    words_nxt = words_r;
    pos       = fill_r;
    if (in_fire) begin
      if (req_clear) begin
        for (int k = 0; k < WIN_LEN; k++) win_nxt[k] = '0;
        cmd_nxt = CMD_NONE;
      end else begin
        if (rx_byte == CH_OPEN) begin
          pos = '0;
          for (int k = 1; k < WIN_LEN; k++) win_nxt[k] = '0;
        end
        if (pos < FW'(BUFFER_LENGTH)) begin
          for (int k = 0; k < WIN_LEN; k++) begin
            if (pos == FW'(k)) win_nxt[k] = rx_byte;
          end
          fill_nxt = pos + FW'(1);
        end else begin
          for (int k = 0; k < WIN_LEN; k++) win_nxt[k] = '0;
          fill_nxt = '0;
        end
        if (win_nxt[0] == CH_OPEN) begin
          if (win_nxt[2] == CH_CLOSE) begin
            case (win_nxt[1])
              CH_ONE:  cmd_nxt = CMD_ONE;
              CH_TWO:  cmd_nxt = CMD_TWO;
              CH_Q:    cmd_nxt = CMD_Q;
              CH_S:    cmd_nxt = CMD_S;
              default: cmd_nxt = cmd_r;
            endcase
          end else if (win_nxt[9] == CH_CLOSE) begin
            if (win_nxt[1] == CH_BIG_P && win_nxt[8] == CH_SMALL_P) begin
              words_nxt[0] = {win_nxt[2], win_nxt[3]};
              words_nxt[1] = {win_nxt[4], win_nxt[5]};
              words_nxt[2] = {win_nxt[6], win_nxt[7]};
            end
            cmd_nxt = CMD_SETTINGS;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_LEN; k++) win_r[k] <= '0;
      for (int k = 0; k < 3; k++) words_r[k] <= '0;
      fill_r <= '0;
      cmd_r  <= CMD_NONE;
    end else begin
      win_r   <= win_nxt;
      words_r <= words_nxt;
      fill_r  <= fill_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign res.command        = cmd_nxt;
  assign res.setting_first  = words_nxt[0];
  assign res.setting_second = words_nxt[1];
  assign res.setting_third  = words_nxt[2];

`include "angle_frame_command_decoder_core_assert.svh"

  `AFCD_ASSERT_SAME(a_fill_range, 1'b1, fill_r <= FW'(BUFFER_LENGTH))
  `AFCD_ASSERT_NEXT(a_clear_cmd, in_fire && req_clear, cmd_r == CMD_NONE && win_r[0] == 8'h00)
  `AFCD_ASSERT_SAME(a_open_at_head, 1'b1, win_r[1] != CH_OPEN && win_r[9] != CH_OPEN)

endmodule

/* hdl/afcd_out_buf.sv */
`timescale 1ns / 1ps

module afcd_out_buf import afcd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    push, pop;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid_r && out_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      main_r <= skid_valid_r ? skid_r : in_data;
    end else if (push) begin
      skid_r <= in_data;
    end
  end

`include "angle_frame_command_decoder_core_assert.svh"

  `AFCD_ASSERT_SAME(a_skid_needs_main, skid_valid_r, main_valid_r)
  `AFCD_ASSERT_NEXT(a_stall_to_skid, push && main_valid_r && !out_ready, skid_valid_r)
  `AFCD_ASSERT_NEXT(a_skid_drain, skid_valid_r && out_ready, main_valid_r && !skid_valid_r)

endmodule

/* hdl/angle_frame_command_decoder_core.sv */
`timescale 1ns / 1ps

// Frame command decoder for angle-bracket serial frames. Each transfer on
// the input is a received byte (in_tuser low) or a clear request (in_tuser
// high); each yields exactly one result transfer carrying the sticky command
// and the three setting words. One item can be taken every clock cycle while
// in_tready is high; its result is registered in the output buffer and
// presented from its main entry. A two-entry output buffer absorbs one
// result while the output stalls: in_tready drops only while both entries
// hold results not yet taken, and rises again the cycle after the output
// takes one.
module angle_frame_command_decoder_core import afcd_pkg::*; #(
  parameter int unsigned BUFFER_LENGTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [2:0] command, [18:3] setting_first,
                                  // [34:19] setting_second, [50:35] setting_third,
                                  // [55:51] zero
);

  result_t res, res_out;
  logic    in_fire;

  assign in_fire = in_tvalid && in_tready;

  afcd_frame #(
    .BUFFER_LENGTH(BUFFER_LENGTH)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .req_clear(in_tuser),
    .rx_byte  (in_tdata),
    .res      (res)
  );

  afcd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (res_out)
  );

  assign out_tdata = {5'b0, res_out.setting_third, res_out.setting_second,
                      res_out.setting_first, res_out.command};

endmodule

/* tb/angle_frame_command_decoder_core_tb.sv */
`timescale 1ns / 1ps

module angle_frame_command_decoder_core_tb;
  import afcd_pkg::*;

  localparam int unsigned BUF_LEN    = 16;
  localparam int unsigned ITEM_COUNT = 1050;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam bit REQ_BYTE  = 1'b0;
  localparam bit REQ_CLEAR = 1'b1;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  angle_frame_command_decoder_core #(.BUFFER_LENGTH(BUF_LEN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Tracks the frame buffer, sticky command and setting words; holds the
  // results still owed by the block.
  class frame_cmd_scoreboard;
    logic [7:0]  frame [BUF_LEN];
    int unsigned fill_pos;
    cmd_t        held_cmd;
    logic [15:0] words [3];
    result_t     cmd_queue [$];
    int unsigned errors;

    function new();
      foreach (frame[k]) frame[k] = 8'h00;
      foreach (words[k]) words[k] = 16'h0000;
      fill_pos = 0;
      held_cmd = CMD_NONE;
      errors   = 0;
    endfunction

    function logic [7:0] byte_at(int unsigned idx);
      return (idx < BUF_LEN) ? frame[idx] : 8'h00;
    endfunction

    function void accept_request(bit req, logic [7:0] rx);
      result_t r;
      if (req == REQ_BYTE) begin
        if (rx == CH_OPEN) begin
          fill_pos = 0;
          for (int k = 1; k < BUF_LEN; k++) frame[k] = 8'h00;
        end
        if (fill_pos < BUF_LEN) begin
          frame[fill_pos] = rx;
          fill_pos++;
        end else begin
          // full buffer: wipe and drop the byte
          foreach (frame[k]) frame[k] = 8'h00;
          fill_pos = 0;
        end
        for (int unsigned i = 0; i < BUF_LEN; i++) begin
          if (byte_at(i) != CH_OPEN) continue;
          if (byte_at(i + 2) == CH_CLOSE) begin
            case (byte_at(i + 1))
              CH_ONE:  held_cmd = CMD_ONE;
              CH_TWO:  held_cmd = CMD_TWO;
              CH_Q:    held_cmd = CMD_Q;
              CH_S:    held_cmd = CMD_S;
              default: ;
            endcase
          end else if (byte_at(i + 9) == CH_CLOSE) begin
            if (byte_at(i + 1) == CH_BIG_P && byte_at(i + 8) == CH_SMALL_P) begin
              words[0] = {byte_at(2), byte_at(3)};
              words[1] = {byte_at(4), byte_at(5)};
              words[2] = {byte_at(6), byte_at(7)};
            end
            held_cmd = CMD_SETTINGS;
          end
        end
      end else begin
        foreach (frame[k]) frame[k] = 8'h00;
        held_cmd = CMD_NONE;
      end
      r.command        = held_cmd;
      r.setting_first  = words[0];
      r.setting_second = words[1];
      r.setting_third  = words[2];
      cmd_queue.push_back(r);
    endfunction

    function void check_result(logic [55:0] data);
      result_t got;
      result_t want;
      got = data[50:0];
      if (cmd_queue.size() == 0) begin
        if (errors < 10) $display("%0t: result %h with none outstanding", $realtime, data);
        errors++;
        return;
      end
      want = cmd_queue.pop_front();
      if (got !== want || data[55:51] !== 5'd0) begin
        if (errors < 10)
          $display("%0t: mismatch cmd %0d/%0d first %h/%h second %h/%h third %h/%h pad %h",
                   $realtime, want.command, got.command, want.setting_first,
                   got.setting_first, want.setting_second, got.setting_second,
                   want.setting_third, got.setting_third, data[55:51]);
        errors++;
      end
    endfunction
  endclass

  frame_cmd_scoreboard sb = new();

  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // transfer monitor; inputs are noted before results are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) sb.accept_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(bit req, logic [7:0] rx);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic drain_results();
    while (sb.cmd_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_OPEN) ? (b ^ 8'h01) : b;
  endfunction

  // result sink with random stalls
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0] seq [$];
    logic [7:0] cmd_chars [4];
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    bit          drained;
    cmd_chars = '{CH_ONE, CH_TWO, CH_Q, CH_S};
    drained   = 1'b0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: command frame, unknown command char, settings frame with
    // extreme bytes, clear item, plain ten-byte frame
    seq = '{CH_OPEN, CH_ONE, CH_CLOSE,
            CH_OPEN, 8'h00, CH_CLOSE,
            CH_OPEN, CH_BIG_P, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01,
            CH_SMALL_P, CH_CLOSE};
    foreach (seq[k]) send_item(REQ_BYTE, seq[k]);
    send_item(REQ_CLEAR, 8'hFF);
    seq = '{CH_OPEN, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, CH_CLOSE};
    foreach (seq[k]) send_item(REQ_BYTE, seq[k]);

    // hold off until the block has caught up
    @(negedge clk) in_tvalid <= 1'b0;
    drain_results();

    while (items_sent < ITEM_COUNT) begin
      if (!drained && items_sent > ITEM_COUNT / 2) begin
        @(negedge clk) in_tvalid <= 1'b0;
        drain_results();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 9);
      seq.delete();
      case (kind)
        0, 1, 2: begin
          seq.push_back(CH_OPEN);
          seq.push_back(($urandom_range(0, 4) == 0) ? plain_byte()
                                                    : cmd_chars[2'($urandom_range(0, 3))]);
          seq.push_back(CH_CLOSE);
          n = $urandom_range(0, 4);
          repeat (n) seq.push_back(plain_byte());
        end
        3, 4: begin
          seq.push_back(CH_OPEN);
          seq.push_back(CH_BIG_P);
          repeat (6) seq.push_back(8'($urandom_range(0, 255)));
          seq.push_back(CH_SMALL_P);
          seq.push_back(CH_CLOSE);
          if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(1, 9);
            seq[pos] = plain_byte();
          end
        end
        5: begin
          seq.push_back(CH_OPEN);
          repeat (8) seq.push_back(plain_byte());
          seq.push_back(CH_CLOSE);
        end
        6: begin
          n = $urandom_range(14, 20);
          repeat (n) seq.push_back(plain_byte());
        end
        7: ;
        default: begin
          n = $urandom_range(1, 5);
          repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      if (kind == 7) send_item(REQ_CLEAR, 8'($urandom_range(0, 255)));
      else foreach (seq[k]) send_item(REQ_BYTE, seq[k]);
    end

    @(negedge clk) in_tvalid <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.cmd_queue.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
